// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define LFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition must never be seen at a clock edge out of reset
`define LFR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LFR_ASSERT(lbl, prop)
`define LFR_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types, constants and helper functions of the lin frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  // bytes per frame: data bytes plus the checksum byte
  localparam int unsigned FrameBytes  = 9;
  localparam int unsigned DataLen     = FrameBytes - 1;
  localparam int unsigned NumDataOut  = 8;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] SyncByte     = 8'h55;
  localparam logic [7:0] BreakByte    = 8'h00;
  localparam logic [7:0] IdMask       = 8'h3F;
  localparam logic [5:0] DiagMasterId = 6'h3C;
  localparam logic [5:0] DiagSlaveId  = 6'h3D;

  typedef enum logic [1:0] {
    PhBreak = 2'd0,
    PhSync  = 2'd1,
    PhPid   = 2'd2,
    PhData  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdTick  = 2'd1,
    CmdFault = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CfgEnhanced = 2'd0,
    CfgBreakGap = 2'd1,
    CfgTimeout  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StMaster      = 2'd0,
    StSlave       = 2'd1,
    StChecksumErr = 2'd2,
    StParityErr   = 2'd3
  } status_e;

  typedef struct packed {
    logic        enhanced;
    logic [15:0] break_gap;
    logic [15:0] timeout;
  } cfg_t;

  // completed frame as handed from the front to the back
  typedef struct packed {
    logic                          ok;
    logic                          enhanced;
    logic [7:0]                    pid;
    logic [7:0]                    crc;
    logic [7:0]                    sum_classic;
    logic [7:0]                    sum_master;
    logic [7:0]                    sum_slave;
    logic [NumDataOut-1:0][7:0]    data;
  } frame_rec_t;

  typedef struct packed {
    status_e                       status;
    logic [5:0]                    id;
    logic [NumDataOut-1:0][7:0]    data;
  } result_t;

  // identifier with its two parity bits
  function automatic logic [7:0] pid_parity(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // add with end-around carry
  function automatic logic [7:0] lin_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/lfr_queue.sv =====
// ----------------------------------------------------------------------------
// lfr_queue
// small queue of completed frames between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lfr_pkg::frame_rec_t rec_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output lfr_pkg::frame_rec_t    rec_o
);
  import lfr_pkg::*;

  frame_rec_t         mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  `LFR_ASSERT(a_cnt_bound, cnt_q <= QCntW'(QueueDepth))
  `LFR_ASSERT_NEVER(a_no_push_full, push_i && full_o)
  `LFR_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))

endmodule

`default_nettype wire

// ===== design/lfr_front.sv =====
// ----------------------------------------------------------------------------
// lfr_front
// frame tracker: phases, idle ticks, data capture and running checksums
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lfr_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   rec_valid_o,
  output lfr_pkg::frame_rec_t    rec_o
);
  import lfr_pkg::*;

  phase_e       phase_q, phase_d, phase_eff;
  logic [7:0]   pid_q, pid_d;
  logic         ok_q, ok_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [15:0]  idle_q, idle_d;
  logic         seen_q, seen_d;
  logic [7:0]   sum_cl_q, sum_cl_d;
  logic [7:0]   sum_m_q, sum_m_d;
  logic [7:0]   sum_s_q, sum_s_d;
  logic [7:0]   data_q [NumDataOut];
  logic         data_we;
  logic         is_byte;
  logic         last_byte;

  assign is_byte   = in_valid_i && (cmd_i == CmdByte);
  assign last_byte = (cnt_q >= 4'(DataLen));

  // gap and data timeouts push the byte back to the break phase
  always_comb begin
    phase_eff = phase_q;
    if (seen_q && (idle_q > cfg_i.break_gap)) begin
      phase_eff = PhBreak;
    end
    if ((phase_eff == PhData) && (idle_q > cfg_i.timeout)) begin
      phase_eff = PhBreak;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_valid_i && (cmd_i == CmdFault)) begin
      phase_d = PhBreak;
    end else if (is_byte) begin
      case (phase_eff)
        PhBreak: begin
          if (rx_byte_i == BreakByte) begin
            phase_d = PhSync;
          end else if (rx_byte_i == SyncByte) begin
            phase_d = PhPid;
          end else begin
            phase_d = PhBreak;
          end
        end
        PhSync: begin
          if (rx_byte_i == SyncByte) begin
            phase_d = PhPid;
          end else if (rx_byte_i == BreakByte) begin
            phase_d = PhSync;
          end else begin
            phase_d = PhBreak;
          end
        end
        PhPid: phase_d = PhData;
        PhData: phase_d = last_byte ? PhBreak : PhData;
        default: phase_d = PhBreak;
      endcase
    end
  end

  // frame datapath
  always_comb begin
    pid_d       = pid_q;
    ok_d        = ok_q;
    cnt_d       = cnt_q;
    idle_d      = idle_q;
    seen_d      = seen_q;
    sum_cl_d    = sum_cl_q;
    sum_m_d     = sum_m_q;
    sum_s_d     = sum_s_q;
    data_we     = 1'b0;
    rec_valid_o = 1'b0;
    if (in_valid_i) begin
      case (cmd_i)
        CmdTick: begin
          if (idle_q != '1) begin
            idle_d = idle_q + 16'd1;
          end
        end
        CmdFault: begin
          pid_d  = '0;
          ok_d   = 1'b1;
          cnt_d  = '0;
          idle_d = '0;
          seen_d = 1'b0;
        end
        CmdByte: begin
          idle_d = '0;
          seen_d = 1'b1;
          case (phase_eff)
            PhBreak: begin
              cnt_d = '0;
              ok_d  = 1'b1;
              pid_d = '0;
            end
            PhPid: begin
              pid_d    = rx_byte_i;
              sum_cl_d = '0;
              sum_m_d  = rx_byte_i & IdMask;
              sum_s_d  = rx_byte_i;
              if (cfg_i.enhanced && (rx_byte_i != pid_parity(rx_byte_i[5:0]))) begin
                ok_d = 1'b0;
              end
            end
            PhData: begin
              cnt_d = cnt_q + 4'd1;
              if (last_byte) begin
                rec_valid_o = 1'b1;
              end else begin
                data_we  = 1'b1;
                sum_cl_d = lin_add(sum_cl_q, rx_byte_i);
                sum_m_d  = lin_add(sum_m_q, rx_byte_i);
                sum_s_d  = lin_add(sum_s_q, rx_byte_i);
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rec_o.ok          = ok_q;
    rec_o.enhanced    = cfg_i.enhanced;
    rec_o.pid         = pid_q;
    rec_o.crc         = rx_byte_i;
    rec_o.sum_classic = sum_cl_q;
    rec_o.sum_master  = sum_m_q;
    rec_o.sum_slave   = sum_s_q;
    for (int i = 0; i < NumDataOut; i++) begin
      rec_o.data[i] = (i < DataLen) ? data_q[i] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhBreak;
      pid_q    <= '0;
      ok_q     <= 1'b1;
      cnt_q    <= '0;
      idle_q   <= '0;
      seen_q   <= 1'b0;
      sum_cl_q <= '0;
      sum_m_q  <= '0;
      sum_s_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      pid_q    <= pid_d;
      ok_q     <= ok_d;
      cnt_q    <= cnt_d;
      idle_q   <= idle_d;
      seen_q   <= seen_d;
      sum_cl_q <= sum_cl_d;
      sum_m_q  <= sum_m_d;
      sum_s_q  <= sum_s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_q[cnt_q[2:0]] <= rx_byte_i;
    end
  end

  `LFR_ASSERT(a_rec_in_data, rec_valid_o |-> (phase_q == PhData))
  `LFR_ASSERT(a_break_after_rec, rec_valid_o |=> (phase_q == PhBreak))
  `LFR_ASSERT(a_cnt_bound, cnt_q <= 4'(FrameBytes))

endmodule

`default_nettype wire

// ===== design/lfr_back.sv =====
// ----------------------------------------------------------------------------
// lfr_back
// checksum and status evaluation with a small result queue
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rec_valid_i,
  input  wire lfr_pkg::frame_rec_t rec_i,
  output logic                     rec_pop_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output lfr_pkg::result_t         res_o
);
  import lfr_pkg::*;

  result_t            res_q [QueueDepth];
  result_t            res_new;
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_pop;
  logic [5:0]         id;
  logic               classic;
  logic               sum_ok;
  logic               from_master;
  logic [7:0]         chk_m, chk_s;

  assign empty_o   = (cnt_q == '0);
  assign do_pop    = pop_i && !empty_o;
  assign rec_pop_o = rec_valid_i && (cnt_q != QCntW'(QueueDepth));
  assign res_o     = res_q[rd_ptr_q];

  // status of the frame at the queue head
  always_comb begin
    id          = rec_i.pid[5:0];
    classic     = !rec_i.enhanced || (id == DiagMasterId) || (id == DiagSlaveId);
    chk_m       = ~rec_i.sum_master;
    chk_s       = ~rec_i.sum_slave;
    if (classic) begin
      sum_ok      = (rec_i.crc == ~rec_i.sum_classic);
      from_master = (id != DiagSlaveId);
    end else begin
      sum_ok      = (rec_i.crc == chk_m) || (rec_i.crc == chk_s);
      from_master = (rec_i.crc != chk_s);
    end
    res_new.id   = id;
    res_new.data = rec_i.data;
    if (!rec_i.ok) begin
      res_new.status = StParityErr;
    end else if (!sum_ok) begin
      res_new.status = StChecksumErr;
    end else if (from_master) begin
      res_new.status = StMaster;
    end else begin
      res_new.status = StSlave;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (rec_pop_o && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!rec_pop_o && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (rec_pop_o) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

`default_nettype wire

// ===== design/lin_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// lin_frame_receiver_top
// lin bus frame receiver: follows break, sync, identifier and data, reports
// each complete frame with its checksum and parity status
// ----------------------------------------------------------------------------
// result path: a frame's record enters the frame queue when the item with its
//   checksum byte is accepted, then moves to the result queue when that has room
// throughput: one item per cycle, every item handled by the frame tracker as it
//   is accepted; input stalls only while the frame queue is full
// reset: rst_ni is asynchronous and active low; registers return to enhanced
//   mode, gap 14 and timeout 100, both queues are emptied, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module lin_frame_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // input items
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  // result items
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       frame_status_o,
  output logic [5:0]       frame_id_o,
  output logic [7:0]       data_byte0_o,
  output logic [7:0]       data_byte1_o,
  output logic [7:0]       data_byte2_o,
  output logic [7:0]       data_byte3_o,
  output logic [7:0]       data_byte4_o,
  output logic [7:0]       data_byte5_o,
  output logic [7:0]       data_byte6_o,
  output logic [7:0]       data_byte7_o
);
  import lfr_pkg::*;

  cfg_t        cfg_q;
  logic        in_accept;
  logic        rec_valid;
  frame_rec_t  rec_front;
  frame_rec_t  rec_head;
  logic        mid_full;
  logic        mid_empty;
  logic        mid_pop;
  result_t     res;

  // configuration registers; write only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enhanced  <= 1'b1;
      cfg_q.break_gap <= 16'd14;
      cfg_q.timeout   <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEnhanced: cfg_q.enhanced  <= cfg_data_i[0];
        CfgBreakGap: cfg_q.break_gap <= cfg_data_i;
        CfgTimeout:  cfg_q.timeout   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side stalls only when the frame queue has no room left, so a
  // frame-ending byte always finds a free slot
  assign full      = mid_full;
  assign in_accept = push && !full;

  // front: classifies every item and tracks the frame
  lfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_accept),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_front)
  );

  // decoupling queue of completed frames
  lfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .rec_i   (rec_front),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .rec_o   (rec_head)
  );

  // back: status evaluation and result queue
  lfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!mid_empty),
    .rec_i       (rec_head),
    .rec_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  // oldest waiting result item
  assign frame_status_o = res.status;
  assign frame_id_o     = res.id;
  assign data_byte0_o   = res.data[0];
  assign data_byte1_o   = res.data[1];
  assign data_byte2_o   = res.data[2];
  assign data_byte3_o   = res.data[3];
  assign data_byte4_o   = res.data[4];
  assign data_byte5_o   = res.data[5];
  assign data_byte6_o   = res.data[6];
  assign data_byte7_o   = res.data[7];

endmodule

`default_nettype wire
